### rtl/atcl_pkg.sv
// Shared constants, codes and beat types of the AT command line recognizer.
`timescale 1ns / 1ps

package atcl_pkg;

	localparam int LINE_CAP = 64;
	localparam int NUM_CMDS = 16;
	localparam int NAME_MAX = 16;

	localparam int LS_AW = $clog2(LINE_CAP);
	localparam int NT_EW = $clog2(NUM_CMDS);
	localparam int NT_CW = $clog2(NAME_MAX);
	localparam int CNT_W = NT_EW + 1;
	localparam int CAP_W = 7;
	localparam int CFG_DW = 7;

	localparam logic [CAP_W-1:0] MIN_CAP = CAP_W'(8);
	localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(LINE_CAP);
	localparam logic [CAP_W-1:0] RESET_CAP = CAP_W'(64);
	localparam logic [CNT_W-1:0] MAX_CMDS = CNT_W'(NUM_CMDS);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_DEL = 8'h7F;

	typedef enum logic [1:0] {
		OP_FEED = 2'd0,
		OP_TABLE_WR = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		OUT_NONE = 2'd0,
		OUT_MATCH = 2'd1,
		OUT_UNKNOWN = 2'd2,
		OUT_NO_PREFIX = 2'd3
	} outcome_t;

	typedef enum logic {
		REG_COMMANDS_IN_USE = 1'b0,
		REG_LINE_CAPACITY = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		opcode_t opcode;
		logic [7:0] data_byte;
		logic [3:0] entry_number;
		logic [3:0] char_position;
		logic [5:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic line_done;
		outcome_t outcome;
		logic [3:0] command_number;
		logic [5:0] name_offset;
		logic [5:0] name_length;
		logic [5:0] args_offset;
		logic [5:0] args_length;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic [LS_AW-1:0] addr;
		logic [7:0] data;
	} ls_wr_t;

	typedef struct packed {
		logic vld;
		logic [7:0] data;
	} ls_rsp_t;

	typedef struct packed {
		logic en;
		logic [NT_EW-1:0] entry;
		logic [NT_CW-1:0] pos;
		logic [7:0] data;
	} nt_wr_t;

	typedef struct packed {
		logic vld;
		logic [NT_EW-1:0] row;
		logic hit;
	} nt_rsp_t;

	typedef logic [NAME_MAX-1:0][7:0] name_row_t;

endpackage

### rtl/atcl_line_store.sv
// Line store: one write port, one registered read port, per-byte valid bits.
`timescale 1ns / 1ps

module atcl_line_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  atcl_pkg::ls_wr_t           wr,
	input  logic                       rd_en,
	input  logic [atcl_pkg::LS_AW-1:0] rd_addr,
	output atcl_pkg::ls_rsp_t          rsp
);

	logic [7:0] mem [atcl_pkg::LINE_CAP];
	logic [atcl_pkg::LINE_CAP-1:0] vld_q;
	logic [7:0] rd_data_s1;
	logic rd_hit_s1;
	logic rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_hit_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	// never-written bytes read as zero
	assign rsp.vld = rd_vld_s1;
	assign rsp.data = rd_data_s1 & {8{rd_hit_s1}};

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.en && rd_en))
		else $error("line store read and write in the same cycle");

endmodule

### rtl/atcl_name_table.sv
// Name table: one row per command, byte writes, row reads with name compare.
`timescale 1ns / 1ps

module atcl_name_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  atcl_pkg::nt_wr_t           wr,
	input  logic                       rd_en,
	input  logic [atcl_pkg::NT_EW-1:0] rd_row,
	input  atcl_pkg::name_row_t        name,
	input  logic [5:0]                 name_len,
	output atcl_pkg::nt_rsp_t          rsp
);

	atcl_pkg::name_row_t mem [atcl_pkg::NUM_CMDS];
	logic [atcl_pkg::NUM_CMDS-1:0][atcl_pkg::NAME_MAX-1:0] vld_q;
	atcl_pkg::name_row_t row_s1;
	logic [atcl_pkg::NAME_MAX-1:0] row_vld_s1;
	logic [atcl_pkg::NT_EW-1:0] row_idx_s1;
	logic rd_vld_s1;

	atcl_pkg::name_row_t entry;
	logic [atcl_pkg::NAME_MAX-1:0] char_ok;
	logic fits;
	logic full_len;
	logic term_ok;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.entry][wr.pos] <= wr.data;
		end
		if (rd_en) begin
			row_s1 <= mem[rd_row];
			row_vld_s1 <= vld_q[rd_row];
			row_idx_s1 <= rd_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (wr.en) begin
				vld_q[wr.entry][wr.pos] <= 1'b1;
			end
		end
	end

	// positions below the name length must agree; the entry must end right after
	always_comb begin
		for (int j = 0; j < atcl_pkg::NAME_MAX; j++) begin
			entry[j] = row_s1[j] & {8{row_vld_s1[j]}};
			char_ok[j] = (entry[j] == name[j]) || (6'(j) >= name_len);
		end
	end

	assign fits = name_len <= 6'(atcl_pkg::NAME_MAX);
	assign full_len = name_len == 6'(atcl_pkg::NAME_MAX);
	assign term_ok = full_len || (entry[name_len[atcl_pkg::NT_CW-1:0]] == atcl_pkg::CH_NUL);

	assign rsp.vld = rd_vld_s1;
	assign rsp.row = row_idx_s1;
	assign rsp.hit = fits && (&char_ok) && term_ok;

endmodule

### rtl/at_command_line_recognizer_top.sv
// Feed, table write and unused opcodes reach the output register through ST_RESULT once the
// beat is taken, a line store read through ST_RDWAIT and then ST_RESULT. A CR or LF that ends a
// line that is neither empty nor discarded is scanned in ST_SCAN, then searched in ST_MATCH.
// One item is in flight at a time; both scans run one line store byte or one table row a cycle.
// Reset clears control, configuration and valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps

module at_command_line_recognizer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  atcl_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output atcl_pkg::out_item_t         out_data,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [atcl_pkg::CFG_DW-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RDWAIT = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_MATCH = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	typedef enum logic [5:0] {
		PH_LEAD = 6'b000001,
		PH_GOT_A = 6'b000010,
		PH_GOT_T = 6'b000100,
		PH_NAME = 6'b001000,
		PH_ARGSP = 6'b010000,
		PH_ARGS = 6'b100000
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	logic [atcl_pkg::CNT_W-1:0] cmds_q;
	logic [atcl_pkg::CAP_W-1:0] cap_q;
	logic [atcl_pkg::CAP_W-1:0] eff_cap;
	logic [atcl_pkg::CAP_W-1:0] fill_limit;
	logic [atcl_pkg::CNT_W-1:0] cmd_cnt;

	logic [atcl_pkg::LS_AW-1:0] fill_q, fill_d;
	logic disc_q, disc_d;

	atcl_pkg::out_item_t res_q;
	logic out_valid_q;
	atcl_pkg::out_item_t out_data_q;

	logic [atcl_pkg::LS_AW-1:0] scan_ptr_q;
	logic [atcl_pkg::LS_AW-1:0] pos_s1;
	logic [5:0] ns_q, len_q, a_q, end_q;
	atcl_pkg::name_row_t name_q;
	logic [atcl_pkg::CNT_W-1:0] kiss_q;

	atcl_pkg::ls_wr_t ls_wr;
	logic ls_rd_en;
	logic [atcl_pkg::LS_AW-1:0] ls_rd_addr;
	atcl_pkg::ls_rsp_t ls_rsp;

	atcl_pkg::nt_wr_t nt_wr;
	logic nt_rd_en;
	atcl_pkg::nt_rsp_t nt_rsp;

	logic accept;
	logic is_eol;
	logic is_bs;
	logic [7:0] ch;
	logic [5:0] p;
	logic [5:0] name_off;
	logic scan_eval;
	logic scan_fail;
	logic scan_end;
	logic set_ns;
	logic set_len;
	logic set_a;
	logic name_we;
	logic match_hit;
	logic match_miss;
	logic out_free;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_free = !out_valid_q || !out_stall;

	assign eff_cap = (cap_q < atcl_pkg::MIN_CAP) ? atcl_pkg::MIN_CAP :
		((cap_q > atcl_pkg::MAX_CAP) ? atcl_pkg::MAX_CAP : cap_q);
	assign fill_limit = eff_cap - atcl_pkg::CAP_W'(1);
	assign cmd_cnt = (cmds_q > atcl_pkg::MAX_CMDS) ? atcl_pkg::MAX_CMDS : cmds_q;

	assign is_eol = (in_data.data_byte == atcl_pkg::CH_CR) ||
		(in_data.data_byte == atcl_pkg::CH_LF);
	assign is_bs = (in_data.data_byte == atcl_pkg::CH_BS) ||
		(in_data.data_byte == atcl_pkg::CH_DEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmds_q <= '0;
			cap_q <= atcl_pkg::RESET_CAP;
		end else if (cfg_write) begin
			case (cfg_index)
				atcl_pkg::REG_COMMANDS_IN_USE: cmds_q <= cfg_data[atcl_pkg::CNT_W-1:0];
				atcl_pkg::REG_LINE_CAPACITY: cap_q <= cfg_data[atcl_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// input decode and state machine: fill pointer, store writes and reads, next state
	always_comb begin
		fill_d = fill_q;
		disc_d = disc_q;
		ls_wr = '0;
		nt_wr = '0;
		ls_rd_en = 1'b0;
		ls_rd_addr = scan_ptr_q;
		nt_rd_en = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RESULT;
					case (in_data.opcode)
						atcl_pkg::OP_FEED: begin
							if (is_eol) begin
								if (!disc_q && fill_q != '0) begin
									ls_wr.en = 1'b1;
									ls_wr.addr = fill_q;
									ls_wr.data = atcl_pkg::CH_NUL;
									state_d = ST_SCAN;
								end
								fill_d = '0;
								disc_d = 1'b0;
							end else if (!disc_q) begin
								if (is_bs) begin
									if (fill_q != '0) begin
										fill_d = fill_q - atcl_pkg::LS_AW'(1);
									end
								end else if ({1'b0, fill_q} >= fill_limit) begin
									disc_d = 1'b1;
									fill_d = '0;
								end else begin
									ls_wr.en = 1'b1;
									ls_wr.addr = fill_q;
									ls_wr.data = in_data.data_byte;
									fill_d = fill_q + atcl_pkg::LS_AW'(1);
								end
							end
						end
						atcl_pkg::OP_TABLE_WR: begin
							nt_wr.en = 1'b1;
							nt_wr.entry = in_data.entry_number;
							nt_wr.pos = in_data.char_position;
							nt_wr.data = in_data.data_byte;
						end
						atcl_pkg::OP_READ: begin
							ls_rd_en = 1'b1;
							ls_rd_addr = in_data.read_address;
							state_d = ST_RDWAIT;
						end
						default: ;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_RESULT;
			ST_SCAN: begin
				ls_rd_en = 1'b1;
				if (scan_fail) begin
					state_d = ST_RESULT;
				end else if (scan_end) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				nt_rd_en = kiss_q < cmd_cnt;
				if (match_hit || match_miss) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// line scan: leading spaces, "AT+", name, spaces, arguments, up to the terminator
	assign ch = ls_rsp.data;
	assign p = pos_s1;
	assign name_off = p - ns_q;
	assign scan_eval = (state_q == ST_SCAN) && ls_rsp.vld;

	always_comb begin
		phase_d = phase_q;
		scan_fail = 1'b0;
		scan_end = 1'b0;
		set_ns = 1'b0;
		set_len = 1'b0;
		set_a = 1'b0;
		name_we = 1'b0;
		if (scan_eval) begin
			case (phase_q)
				PH_LEAD: begin
					if (ch == atcl_pkg::CH_A) begin
						phase_d = PH_GOT_A;
					end else if (ch != atcl_pkg::CH_SP) begin
						scan_fail = 1'b1;
					end
				end
				PH_GOT_A: begin
					if (ch == atcl_pkg::CH_T) begin
						phase_d = PH_GOT_T;
					end else begin
						scan_fail = 1'b1;
					end
				end
				PH_GOT_T: begin
					if (ch == atcl_pkg::CH_PLUS) begin
						set_ns = 1'b1;
						phase_d = PH_NAME;
					end else begin
						scan_fail = 1'b1;
					end
				end
				PH_NAME: begin
					if (ch == atcl_pkg::CH_NUL) begin
						set_len = 1'b1;
						set_a = 1'b1;
						scan_end = 1'b1;
					end else if (ch == atcl_pkg::CH_SP) begin
						set_len = 1'b1;
						phase_d = PH_ARGSP;
					end else begin
						name_we = name_off < 6'(atcl_pkg::NAME_MAX);
					end
				end
				PH_ARGSP: begin
					if (ch == atcl_pkg::CH_NUL) begin
						set_a = 1'b1;
						scan_end = 1'b1;
					end else if (ch != atcl_pkg::CH_SP) begin
						set_a = 1'b1;
						phase_d = PH_ARGS;
					end
				end
				PH_ARGS: begin
					scan_end = ch == atcl_pkg::CH_NUL;
				end
				default: phase_d = PH_LEAD;
			endcase
		end
	end

	assign match_hit = nt_rsp.vld && nt_rsp.hit;
	assign match_miss = (kiss_q == cmd_cnt) && !nt_rsp.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LEAD;
			fill_q <= '0;
			disc_q <= 1'b0;
			out_valid_q <= 1'b0;
			scan_ptr_q <= '0;
			kiss_q <= '0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			disc_q <= disc_d;
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// rewind the line walk while idle and the row walk while scanning
			if (state_q == ST_IDLE) begin
				scan_ptr_q <= '0;
				phase_q <= PH_LEAD;
			end else if (state_q == ST_SCAN) begin
				scan_ptr_q <= scan_ptr_q + atcl_pkg::LS_AW'(1);
				phase_q <= phase_d;
			end
			if (state_q == ST_SCAN) begin
				kiss_q <= '0;
			end else if (nt_rd_en) begin
				kiss_q <= kiss_q + atcl_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= scan_ptr_q;
		if (set_ns) begin
			ns_q <= p + 6'd1;
		end
		if (set_len) begin
			len_q <= name_off;
		end
		if (set_a) begin
			a_q <= p;
		end
		if (scan_end) begin
			end_q <= p;
		end
		if (name_we) begin
			name_q[name_off[atcl_pkg::NT_CW-1:0]] <= ch;
		end
		if (state_q == ST_RESULT && out_free) begin
			out_data_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_q <= '0;
				end
			end
			ST_RDWAIT: res_q.read_data <= ls_rsp.data;
			ST_SCAN: begin
				if (scan_fail) begin
					res_q.outcome <= atcl_pkg::OUT_NO_PREFIX;
				end
			end
			ST_MATCH: begin
				if (match_hit || match_miss) begin
					res_q.line_done <= 1'b1;
					res_q.outcome <= match_hit ? atcl_pkg::OUT_MATCH : atcl_pkg::OUT_UNKNOWN;
					res_q.command_number <= match_hit ? nt_rsp.row : '0;
					res_q.name_offset <= ns_q;
					res_q.name_length <= len_q;
					res_q.args_offset <= a_q;
					res_q.args_length <= end_q - a_q;
				end
			end
			default: ;
		endcase
	end

	atcl_line_store u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ls_wr),
		.rd_en   (ls_rd_en),
		.rd_addr (ls_rd_addr),
		.rsp     (ls_rsp)
	);

	atcl_name_table u_name_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (nt_wr),
		.rd_en    (nt_rd_en),
		.rd_row   (kiss_q[atcl_pkg::NT_EW-1:0]),
		.name     (name_q),
		.name_len (len_q),
		.rsp      (nt_rsp)
	);

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, fill_q} < eff_cap)
		else $error("fill position reached line capacity");

	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> (fill_q == '0))
		else $error("discarding with a non-empty line");

	a_offsets_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MATCH) |->
			(a_q <= end_q) && (({1'b0, ns_q} + {1'b0, len_q}) <= {1'b0, a_q}))
		else $error("name and argument offsets out of order");

	a_row_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		nt_rsp.vld |-> $past(state_q == ST_MATCH))
		else $error("table row returned outside the name search");

endmodule
